// ----- src/tsc_pkg.sv -----
// Shared types, constants and series tables for the Taylor sine/cosine unit.
`default_nettype none

package tsc_pkg;

  localparam int ANGLE_W = 32;
  localparam int VAL_W   = 32;
  localparam int TOL_W   = 31;
  localparam int TERMS_W = 4;
  localparam int N_W     = 5;
  localparam int SHIFT_W = 3;
  localparam int RED_W   = 38;

  // reduction steps subtract 2*pi << 4 down to 2*pi << 0
  localparam logic [SHIFT_W-1:0] RED_TOP_SHIFT = 3'd4;

  localparam logic [RED_W-1:0] TWO_PI_Q30     = 38'd6746518852;
  localparam logic [RED_W-1:0] PI_Q30         = 38'd3373259426;
  localparam logic [RED_W-1:0] HALF_PI_Q30    = 38'd1686629713;
  localparam logic [RED_W-1:0] QUARTER_PI_Q30 = 38'd843314857;
  // 21 * 2*pi, lifts any negative Q30 angle into positive range
  localparam logic [RED_W-1:0] NEG_WRAP_Q30   = 38'd141676895892;
  localparam logic [30:0]      ONE_Q30        = 31'd1073741824;
  localparam logic [63:0]      HALF_LSB_Q30   = 64'd536870912;
  localparam logic [63:0]      TWO32          = 64'h1_0000_0000;
  localparam logic [TOL_W-1:0] TOL_RESET      = 31'd11;

  // datapath operations
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_RED  = 4'd2;
  localparam logic [3:0] OP_F1   = 4'd3;
  localparam logic [3:0] OP_F2   = 4'd4;
  localparam logic [3:0] OP_F3   = 4'd5;
  localparam logic [3:0] OP_SQ   = 4'd6;
  localparam logic [3:0] OP_INIT = 4'd7;
  localparam logic [3:0] OP_TMUL = 4'd8;
  localparam logic [3:0] OP_TY   = 4'd9;
  localparam logic [3:0] OP_TREC = 4'd10;
  localparam logic [3:0] OP_TCOR = 4'd11;
  localparam logic [3:0] OP_TFIX = 4'd12;
  localparam logic [3:0] OP_OUT  = 4'd13;

  // k = 2n(2n+1) for sine, 2n(2n-1) for cosine, n = 1..16
  localparam logic [10:0] SIN_K [16] = '{
    11'd6,   11'd20,  11'd42,  11'd72,  11'd110, 11'd156, 11'd210, 11'd272,
    11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812, 11'd930, 11'd1056};
  localparam logic [10:0] COS_K [16] = '{
    11'd2,   11'd12,  11'd30,  11'd56,  11'd90,  11'd132, 11'd182, 11'd240,
    11'd306, 11'd380, 11'd462, 11'd552, 11'd650, 11'd756, 11'd870, 11'd992};

  // floor(2^32 / k)
  localparam logic [31:0] SIN_R [16] = '{
    32'(TWO32 / 64'd6),   32'(TWO32 / 64'd20),  32'(TWO32 / 64'd42),
    32'(TWO32 / 64'd72),  32'(TWO32 / 64'd110), 32'(TWO32 / 64'd156),
    32'(TWO32 / 64'd210), 32'(TWO32 / 64'd272), 32'(TWO32 / 64'd342),
    32'(TWO32 / 64'd420), 32'(TWO32 / 64'd506), 32'(TWO32 / 64'd600),
    32'(TWO32 / 64'd702), 32'(TWO32 / 64'd812), 32'(TWO32 / 64'd930),
    32'(TWO32 / 64'd1056)};
  localparam logic [31:0] COS_R [16] = '{
    32'(TWO32 / 64'd2),   32'(TWO32 / 64'd12),  32'(TWO32 / 64'd30),
    32'(TWO32 / 64'd56),  32'(TWO32 / 64'd90),  32'(TWO32 / 64'd132),
    32'(TWO32 / 64'd182), 32'(TWO32 / 64'd240), 32'(TWO32 / 64'd306),
    32'(TWO32 / 64'd380), 32'(TWO32 / 64'd462), 32'(TWO32 / 64'd552),
    32'(TWO32 / 64'd650), 32'(TWO32 / 64'd756), 32'(TWO32 / 64'd870),
    32'(TWO32 / 64'd992)};

  typedef struct packed {
    logic [3:0]         op;
    logic [SHIFT_W-1:0] shift;
    logic [N_W-1:0]     term_n;
    logic               capped;
  } cmd_t;

  typedef struct packed {
    logic below_tol;
  } status_t;

endpackage

`default_nettype wire

// ----- src/tsc_datapath.sv -----
// Datapath: range reduction, octant fold, shared multiplier and series accumulator.
`default_nettype none

module tsc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_action,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] in_angle,
  input  logic                               cfg_we,
  input  logic        [tsc_pkg::TOL_W-1:0]   cfg_data,
  input  tsc_pkg::cmd_t                      cmd,
  output tsc_pkg::status_t                   status,
  output logic signed [tsc_pkg::VAL_W-1:0]   out_value,
  output logic        [tsc_pkg::TERMS_W-1:0] out_terms_used,
  output logic signed [tsc_pkg::VAL_W-1:0]   out_last_term,
  output logic                               out_capped
);
  import tsc_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic [RED_W-1:0] x_r, x_nxt;
  logic             cos_r, use_cos_r, sign_neg_r;
  logic [63:0]      prod_r;
  logic [29:0]      sq_r;
  logic [30:0]      m_r, y_r, q0_r;
  logic signed [32:0] sum_r;
  logic             neg_r;

  logic signed [VAL_W-1:0]   value_r, last_r;
  logic        [TERMS_W-1:0] terms_r;
  logic                      capped_r;

  logic [RED_W-1:0] a_ext, red_c;
  logic [3:0]       idx;
  logic [10:0]      k;
  logic [31:0]      recip;
  logic [31:0]      mul_a, mul_b;
  logic             mul_en;
  logic [30:0]      rem, m_calc;
  logic signed [32:0] val_s;
  logic signed [VAL_W-1:0] val_clamped, m_s;

  assign a_ext = {in_angle, 6'b0};
  assign red_c = TWO_PI_Q30 << cmd.shift;
  assign idx   = 4'(cmd.term_n - 5'd1);
  assign k     = use_cos_r ? COS_K[idx] : SIN_K[idx];
  assign recip = use_cos_r ? COS_R[idx] : SIN_R[idx];

  assign rem    = y_r - prod_r[30:0];
  assign m_calc = (rem >= 31'(k)) ? q0_r + 31'd1 : q0_r;
  assign status.below_tol = m_calc < tol_r;

  assign val_s = sign_neg_r ? -sum_r : sum_r;
  assign m_s   = signed'({1'b0, m_r});

  always_comb begin
    if (val_s > signed'({2'b0, ONE_Q30}))
      val_clamped = signed'({1'b0, ONE_Q30});
    else if (val_s < -signed'({2'b0, ONE_Q30}))
      val_clamped = -signed'({1'b0, ONE_Q30});
    else
      val_clamped = val_s[VAL_W-1:0];
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_SQ: begin
        mul_a = {2'b0, x_r[29:0]};
        mul_b = {2'b0, x_r[29:0]};
      end
      OP_TMUL: begin
        mul_a = {1'b0, m_r};
        mul_b = {2'b0, sq_r};
      end
      OP_TREC: begin
        mul_a = {1'b0, y_r};
        mul_b = recip;
      end
      OP_TCOR: begin
        mul_a = {1'b0, prod_r[62:32]};
        mul_b = {21'b0, k};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    x_nxt = x_r;
    case (cmd.op)
      OP_LOAD: x_nxt = a_ext[RED_W-1] ? a_ext + NEG_WRAP_Q30 : a_ext;
      OP_RED:  x_nxt = (x_r >= red_c) ? x_r - red_c : x_r;
      OP_F1:   x_nxt = (x_r > PI_Q30) ? x_r - PI_Q30 : x_r;
      OP_F2:   x_nxt = (x_r > HALF_PI_Q30) ? PI_Q30 - x_r : x_r;
      OP_F3:   x_nxt = (x_r > QUARTER_PI_Q30) ? HALF_PI_Q30 - x_r : x_r;
      default: x_nxt = x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_LOAD: begin
        cos_r      <= in_action;
        sign_neg_r <= 1'b0;
      end
      OP_F1: begin
        if (x_r > PI_Q30) sign_neg_r <= ~sign_neg_r;
      end
      OP_F2: begin
        if (x_r > HALF_PI_Q30 && cos_r) sign_neg_r <= ~sign_neg_r;
      end
      OP_F3: begin
        use_cos_r <= (x_r > QUARTER_PI_Q30) ? ~cos_r : cos_r;
      end
      OP_INIT: begin
        sq_r  <= 30'((prod_r + HALF_LSB_Q30) >> 30);
        m_r   <= use_cos_r ? ONE_Q30 : {1'b0, x_r[29:0]};
        sum_r <= '0;
        neg_r <= 1'b0;
      end
      OP_TMUL: begin
        sum_r <= neg_r ? sum_r - signed'({2'b0, m_r}) : sum_r + signed'({2'b0, m_r});
        neg_r <= ~neg_r;
      end
      OP_TY: begin
        y_r <= 31'((prod_r + (64'(k) << 29)) >> 30);
      end
      OP_TCOR: begin
        q0_r <= prod_r[62:32];
      end
      OP_TFIX: begin
        m_r <= m_calc;
      end
      OP_OUT: begin
        value_r  <= val_clamped;
        last_r   <= neg_r ? -m_s : m_s;
        terms_r  <= cmd.term_n[TERMS_W-1:0];
        capped_r <= cmd.capped;
      end
      default: begin
      end
    endcase
  end

  assign out_value      = value_r;
  assign out_terms_used = terms_r;
  assign out_last_term  = last_r;
  assign out_capped     = capped_r;

endmodule

`default_nettype wire

// ----- src/tsc_controller.sv -----
// Controller: sequences reduction, fold and the per-term series steps.
`default_nettype none

module tsc_controller #(
  parameter int MAX_TERMS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tsc_pkg::status_t status,
  output tsc_pkg::cmd_t    cmd,
  output logic             out_valid
);
  import tsc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F2   = 4'd3;
  localparam logic [3:0] S_F3   = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_INIT = 4'd6;
  localparam logic [3:0] S_TMUL = 4'd7;
  localparam logic [3:0] S_TY   = 4'd8;
  localparam logic [3:0] S_TREC = 4'd9;
  localparam logic [3:0] S_TCOR = 4'd10;
  localparam logic [3:0] S_TFIX = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [N_W-1:0]     n_r, n_nxt;
  logic               capped_r, capped_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         op;

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    n_nxt         = n_r;
    capped_nxt    = capped_r;
    out_valid_nxt = 1'b0;
    op            = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op         = OP_LOAD;
          state_nxt  = S_RED;
          shift_nxt  = RED_TOP_SHIFT;
          n_nxt      = '0;
          capped_nxt = 1'b0;
        end
      end
      S_RED: begin
        op = OP_RED;
        if (shift_r == '0) state_nxt = S_F1;
        else shift_nxt = shift_r - 3'd1;
      end
      S_F1: begin
        op        = OP_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        op        = OP_F2;
        state_nxt = S_F3;
      end
      S_F3: begin
        op        = OP_F3;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        op        = OP_SQ;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        op        = OP_INIT;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        op        = OP_TMUL;
        n_nxt     = n_r + 5'd1;
        state_nxt = S_TY;
      end
      S_TY: begin
        op        = OP_TY;
        state_nxt = S_TREC;
      end
      S_TREC: begin
        op        = OP_TREC;
        state_nxt = S_TCOR;
      end
      S_TCOR: begin
        op        = OP_TCOR;
        state_nxt = S_TFIX;
      end
      S_TFIX: begin
        op = OP_TFIX;
        if (status.below_tol) begin
          state_nxt = S_OUT;
        end else if (n_r >= N_W'(MAX_TERMS)) begin
          capped_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_TMUL;
        end
      end
      S_OUT: begin
        op            = OP_OUT;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shift_r     <= '0;
      n_r         <= '0;
      capped_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      n_r         <= n_nxt;
      capped_r    <= capped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign cmd.op     = op;
  assign cmd.shift  = shift_r;
  assign cmd.term_n = n_r;
  assign cmd.capped = capped_r;

  a_strobe_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_OUT))
    else $error("result strobe without output step");

  a_term_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TFIX) |-> (n_r >= 5'd1 && n_r <= N_W'(MAX_TERMS)))
    else $error("term count out of range");

  a_red_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED) |-> (shift_r <= RED_TOP_SHIFT))
    else $error("reduction shift out of range");

  a_start_launches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_RED && n_r == '0))
    else $error("accepted item did not start reduction");

endmodule

`default_nettype wire

// ----- src/taylor_sine_cosine_unit.sv -----
// Top level of the Taylor-series sine/cosine unit.
//
// Usage:
//   Input: drive in_action (0 sine, 1 cosine) and in_angle (signed Q8.24
//   radians) and raise start; the item is taken on a clock edge with start
//   high and busy low. busy stays high while the item is worked on.
//   Result: out_valid pulses for one cycle with out_value (Q2.30, clamped
//   to +/-1), out_terms_used, out_last_term and out_capped. The receiver
//   cannot stall; the result must be taken in that cycle.
//   Config: term_tolerance is written through cfg_valid/cfg_data;
//   cfg_ready is always high. Write only while idle.
// Sequence:
//   From the accept edge: range reduction steps, fold steps F1, F2 and
//   F3, squaring and series init, the steps TMUL, TY, TREC, TCOR and
//   TFIX for each series term and an output step, then the strobe cycle.
//   The one shared multiplier is used three times per term (product,
//   reciprocal, remainder check).
//   A new item may be taken in the strobe cycle.
// Reset: rst_n low, synchronous; the unit goes idle, tolerance = 11.
`default_nettype none

module taylor_sine_cosine_unit #(
  parameter int MAX_TERMS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [31:0] in_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [3:0]         out_terms_used,
  output logic signed [31:0] out_last_term,
  output logic               out_capped
);
  import tsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tsc_controller #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .status    (status),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  tsc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_angle       (in_angle),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .out_value      (out_value),
    .out_terms_used (out_terms_used),
    .out_last_term  (out_last_term),
    .out_capped     (out_capped)
  );

endmodule

`default_nettype wire
